>>> rtl/core/ic3_pkg.sv
// shared types and constants of the 3x3 image correlator
package ic3_pkg;

  localparam int KSIZE      = 3;
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 16;
  localparam int SCALE_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_W     = 11;
  localparam int SIZE_MIN   = 3;
  localparam int SIZE_RST   = 1024;
  localparam int OUT_IDX_W  = 10;
  localparam int VALUE_W    = 32;

  localparam logic signed [SCALE_W-1:0] SCALE_ONE = 32'sd65536;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERN_TOP = 3'd0,
    REG_KERN_MID = 3'd1,
    REG_KERN_BOT = 3'd2,
    REG_SCALE    = 3'd3,
    REG_COLS     = 3'd4,
    REG_ROWS     = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_MUL,
    S_SUM,
    S_TOT,
    S_ABS,
    S_SCL,
    S_ACC,
    S_SAT
  } state_e;

endpackage

>>> rtl/core/ic3_ram.sv
// generic single-port-write, registered-read memory
module ic3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/image_correlate_3x3.sv
// 3x3 streaming image correlator with line stores in block memory
//
// Pixels arrive in raster order on a valid/ready channel; for every interior
// centre pixel one beat leaves with the kernel sum scaled by a signed Q16.16
// factor, truncated toward zero and saturated to 32 bits, plus the centre's
// row, column and an end-of-frame flag. Border centres give no beat. Both line
// stores share one memory entry per column ({row before, previous row}), so
// each pixel is one read-modify-write of that entry. A pixel that yields no
// beat is accepted with the memory read, then shifted into the window and
// written back; a pixel that yields a beat then goes through the multiply,
// add, scale and saturate sequence and waits in the saturate step while the
// output register holds a beat that a stalled consumer has not taken. One
// pixel is in flight at a time. The memory is not cleared after reset: each
// row is written before the next row reads it, so reads stay defined as long
// as the frame size is not grown mid-frame.
module image_correlate_3x3 import ic3_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [OUT_IDX_W-1:0]  out_row_o,
  output logic [OUT_IDX_W-1:0]  out_col_o,
  output logic                  frame_last_o
);

  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CSZ_W    = $clog2(MAX_COLS + 1);
  localparam int RSZ_W    = $clog2(MAX_ROWS + 1);
  localparam int COLS_RST = (MAX_COLS < SIZE_RST) ? MAX_COLS : SIZE_RST;
  localparam int ROWS_RST = (MAX_ROWS < SIZE_RST) ? MAX_ROWS : SIZE_RST;
  localparam int PROD_W   = PIXEL_BITS + COEF_W + 1;
  localparam int RSUM_W   = PROD_W + 2;
  localparam int SUM_W    = PROD_W + 4;
  localparam int LO_W     = (SUM_W + 1) / 2;
  localparam int HI_W     = SUM_W - LO_W;
  localparam int FULL_W   = SUM_W + SCALE_W;
  localparam int MAG_W    = FULL_W - FRAC_BITS;
  localparam int NTAP     = KSIZE * KSIZE;

  // configuration
  logic [CFG_W-1:0]          kern_q [KSIZE];
  logic signed [SCALE_W-1:0] scale_q;
  logic [CSZ_W-1:0]          cols_q;
  logic [RSZ_W-1:0]          rows_q;
  logic [SIZE_W-1:0]         size_raw;
  logic [CSZ_W-1:0]          cols_clamp;
  logic [RSZ_W-1:0]          rows_clamp;

  // control
  state_e           state_q, state_d;
  logic [COL_W-1:0] col_cnt_q;
  logic [ROW_W-1:0] row_cnt_q;
  logic             in_fire;
  logic             col_wrap, row_wrap;
  logic             out_free;

  // per-pixel datapath
  logic [PIXEL_BITS-1:0]    px_q;
  logic [COL_W-1:0]         icol_q;
  logic [ROW_W-1:0]         irow_q;
  logic                     emit_q;
  logic                     ilast_q;
  logic [PIXEL_BITS-1:0]    win_q [KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod_d [NTAP];
  logic signed [PROD_W-1:0] prod_q [NTAP];
  logic signed [RSUM_W-1:0] rsum_d [KSIZE];
  logic signed [RSUM_W-1:0] rsum_q [KSIZE];
  logic signed [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]         amag_q;
  logic [SCALE_W-1:0]       cmag_q;
  logic                     neg_q;
  logic [LO_W+SCALE_W-1:0]  plo_q;
  logic [HI_W+SCALE_W-1:0]  phi_q;
  logic [FULL_W-1:0]        full_d;
  logic [MAG_W-1:0]         mag_q;
  logic                     mag_over;
  logic [VALUE_W-1:0]       sat_d;

  // line store memory
  logic                      ram_we;
  logic [COL_W-1:0]          ram_waddr;
  logic [2*PIXEL_BITS-1:0]   ram_wdata;
  logic [2*PIXEL_BITS-1:0]   ram_rdata;

  // output register
  logic                      out_valid_q;
  logic [VALUE_W-1:0]        value_q;
  logic [OUT_IDX_W-1:0]      out_row_q;
  logic [OUT_IDX_W-1:0]      out_col_q;
  logic                      frame_last_q;

  // ---------------------------------------------------------------- config
  assign size_raw = cfg_data_i[SIZE_W-1:0];

  always_comb begin
    if (size_raw < SIZE_W'(SIZE_MIN)) begin
      cols_clamp = CSZ_W'(SIZE_MIN);
      rows_clamp = RSZ_W'(SIZE_MIN);
    end else begin
      cols_clamp = (32'(size_raw) > MAX_COLS) ? CSZ_W'(MAX_COLS) : CSZ_W'(size_raw);
      rows_clamp = (32'(size_raw) > MAX_ROWS) ? RSZ_W'(MAX_ROWS) : RSZ_W'(size_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KSIZE; r++) begin
        kern_q[r] <= '0;
      end
      scale_q <= SCALE_ONE;
      cols_q  <= CSZ_W'(COLS_RST);
      rows_q  <= RSZ_W'(ROWS_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_KERN_TOP: kern_q[0] <= cfg_data_i;
        REG_KERN_MID: kern_q[1] <= cfg_data_i;
        REG_KERN_BOT: kern_q[2] <= cfg_data_i;
        REG_SCALE:    scale_q   <= $signed(cfg_data_i[SCALE_W-1:0]);
        REG_COLS:     cols_q    <= cols_clamp;
        REG_ROWS:     rows_q    <= rows_clamp;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign col_wrap   = (32'(col_cnt_q) + 1) >= 32'(cols_q);
  assign row_wrap   = (32'(row_cnt_q) + 1) >= 32'(rows_q);
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (col_wrap) begin
          col_cnt_q <= '0;
          row_cnt_q <= row_wrap ? '0 : row_cnt_q + ROW_W'(1);
        end else begin
          col_cnt_q <= col_cnt_q + COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_WIN;
      S_WIN:  state_d = emit_q ? S_MUL : S_IDLE;
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_TOT;
      S_TOT:  state_d = S_ABS;
      S_ABS:  state_d = S_SCL;
      S_SCL:  state_d = S_ACC;
      S_ACC:  state_d = S_SAT;
      S_SAT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- line stores
  // entry holds {row before previous, previous row} for one column
  assign ram_we    = (state_q == S_WIN);
  assign ram_waddr = icol_q;
  assign ram_wdata = {ram_rdata[PIXEL_BITS-1:0], px_q};

  ic3_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (col_cnt_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (state_q == S_WIN) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int c = 0; c < KSIZE - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      win_q[0][KSIZE-1] <= ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
      win_q[1][KSIZE-1] <= ram_rdata[PIXEL_BITS-1:0];
      win_q[2][KSIZE-1] <= px_q;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        prod_d[r*KSIZE+c] = $signed({1'b0, win_q[r][c]})
                          * $signed(kern_q[r][c*COEF_W +: COEF_W]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      rsum_d[r] = RSUM_W'(prod_q[r*KSIZE]) + RSUM_W'(prod_q[r*KSIZE+1])
                + RSUM_W'(prod_q[r*KSIZE+2]);
    end
  end

  // magnitude product split in two partial products, then truncated by shift
  assign full_d   = (FULL_W'(phi_q) << LO_W) + FULL_W'(plo_q);
  assign mag_over = |mag_q[MAG_W-1:VALUE_W-1];

  always_comb begin
    if (neg_q) begin
      sat_d = mag_over ? VALUE_MIN : VALUE_W'(-mag_q[VALUE_W-1:0]);
    end else begin
      sat_d = mag_over ? VALUE_MAX : mag_q[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q    <= pixel_i;
      icol_q  <= col_cnt_q;
      irow_q  <= row_cnt_q;
      emit_q  <= (32'(row_cnt_q) >= 2) && (32'(col_cnt_q) >= 2);
      ilast_q <= row_wrap && col_wrap;
    end
    if (state_q == S_MUL) begin
      for (int i = 0; i < NTAP; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    if (state_q == S_SUM) begin
      for (int r = 0; r < KSIZE; r++) begin
        rsum_q[r] <= rsum_d[r];
      end
    end
    if (state_q == S_TOT) begin
      sum_q <= SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
    end
    if (state_q == S_ABS) begin
      amag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      cmag_q <= scale_q[SCALE_W-1] ? SCALE_W'(-scale_q) : SCALE_W'(scale_q);
      neg_q  <= sum_q[SUM_W-1] ^ scale_q[SCALE_W-1];
    end
    if (state_q == S_SCL) begin
      plo_q <= amag_q[LO_W-1:0] * cmag_q;
      phi_q <= amag_q[SUM_W-1:LO_W] * cmag_q;
    end
    if (state_q == S_ACC) begin
      mag_q <= full_d[FULL_W-1:FRAC_BITS];
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_SAT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SAT && out_free) begin
      value_q      <= sat_d;
      out_row_q    <= OUT_IDX_W'(irow_q - ROW_W'(1));
      out_col_q    <= OUT_IDX_W'(icol_q - COL_W'(1));
      frame_last_q <= ilast_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = $signed(value_q);
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = frame_last_q;

  // ---------------------------------------------------------------- checks
  a_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_WIN)
    else $error("line store data not consumed the cycle after its read");

  a_write_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN) |-> ram_waddr == $past(col_cnt_q))
    else $error("line store write back to a column other than the one read");

  a_beat_from_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SAT))
    else $error("output beat raised outside the saturate step");

  a_sat_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SAT && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("result left the saturate step without loading the output");

endmodule

>>> tb/correlation_checker.sv
`timescale 1ns / 1ps
// checker for the 3x3 correlator: mirrors config writes, predicts each result beat, compares
module correlation_checker import ic3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            pixel_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic [OUT_IDX_W-1:0]  out_row_i,
  input  logic [OUT_IDX_W-1:0]  out_col_i,
  input  logic                  frame_last_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o
);

  localparam int FRAME_MAX = 1024;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
  } corr_result_t;

  logic [CFG_W-1:0]          kern_row [KSIZE];
  logic signed [SCALE_W-1:0] scale;
  int unsigned               cols;
  int unsigned               rows;

  logic [7:0]  prev_line  [FRAME_MAX];
  logic [7:0]  older_line [FRAME_MAX];
  logic [7:0]  win [KSIZE][KSIZE];
  int unsigned row_cnt;
  int unsigned col_cnt;

  corr_result_t expected_q[$];
  int mismatches = 0;
  int compared = 0;

  assign errors_o  = mismatches;
  assign results_o = compared;

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] data);
    int unsigned s;
    s = data[SIZE_W-1:0];
    if (s < SIZE_MIN) return SIZE_MIN;
    if (s > FRAME_MAX) return FRAME_MAX;
    return s;
  endfunction

  // truncate toward zero by working on magnitudes, then clamp to 32 bits
  function automatic logic [VALUE_W-1:0] scale_sat(input longint sum,
                                                   input logic signed [SCALE_W-1:0] k);
    longint unsigned a;
    longint unsigned c;
    longint unsigned mag;
    logic            neg;
    a   = (sum < 0) ? -sum : sum;
    c   = (k < 0) ? -longint'(k) : longint'(k);
    mag = (a * c) >> FRAC_BITS;
    neg = (sum < 0) != (k < 0);
    if (neg) return (mag >= 64'h8000_0000) ? VALUE_MIN : -mag[VALUE_W-1:0];
    return (mag > 64'h7FFF_FFFF) ? VALUE_MAX : mag[VALUE_W-1:0];
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_KERN_TOP: kern_row[0] = data;
      REG_KERN_MID: kern_row[1] = data;
      REG_KERN_BOT: kern_row[2] = data;
      REG_SCALE:    scale = data[SCALE_W-1:0];
      REG_COLS:     cols = clamp_size(data);
      REG_ROWS:     rows = clamp_size(data);
      default: ;
    endcase
  endtask

  task automatic shift_in_pixel(input logic [7:0] px);
    int unsigned  col;
    int unsigned  row;
    longint       sum;
    longint       w;
    longint       cf;
    corr_result_t r;
    col = col_cnt % FRAME_MAX;
    row = row_cnt;
    for (int rr = 0; rr < KSIZE; rr++) begin
      for (int kk = 0; kk < KSIZE - 1; kk++) win[rr][kk] = win[rr][kk+1];
    end
    win[0][KSIZE-1] = older_line[col];
    win[1][KSIZE-1] = prev_line[col];
    win[2][KSIZE-1] = px;
    older_line[col] = prev_line[col];
    prev_line[col]  = px;

    // border centres give no beat
    if (row >= 2 && col >= 2) begin
      sum = 0;
      for (int rr = 0; rr < KSIZE; rr++) begin
        for (int kk = 0; kk < KSIZE; kk++) begin
          w   = win[rr][kk];
          cf  = $signed(kern_row[rr][COEF_W*kk +: COEF_W]);
          sum += w * cf;
        end
      end
      r.value = scale_sat(sum, scale);
      r.row   = OUT_IDX_W'(row - 1);
      r.col   = OUT_IDX_W'(col - 1);
      r.last  = (row + 1 >= rows) && (col + 1 >= cols);
      expected_q.push_back(r);
    end

    // counters survive size changes; anything at or past the end wraps
    if (col_cnt + 1 >= cols) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= rows) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endtask

  task automatic check_beat();
    corr_result_t want;
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected: value %0d row %0d col %0d",
             $signed(value_i), out_row_i, out_col_i);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      compared++;
      if (value_i !== want.value) begin
        $error("value: expected %0d, got %0d", $signed(want.value), $signed(value_i));
        mismatches++;
      end
      if (out_row_i !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, out_row_i);
        mismatches++;
      end
      if (out_col_i !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, out_col_i);
        mismatches++;
      end
      if (frame_last_i !== want.last) begin
        $error("frame_last: expected %0b, got %0b", want.last, frame_last_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (kern_row[i]) kern_row[i] = '0;
      foreach (win[r, k]) win[r][k] = '0;
      scale   = SCALE_ONE;
      cols    = SIZE_RST;
      rows    = SIZE_RST;
      row_cnt = 0;
      col_cnt = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) shift_in_pixel(pixel_i);
      if (out_valid_i && out_ready_i) check_beat();
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> tb/tb_image_correlate_3x3.sv
`timescale 1ns / 1ps
// top of the 3x3 correlator testbench: clock, reset, pixel and config stimulus, verdict
module tb_image_correlate_3x3 import ic3_pkg::*; ();

  localparam int CLK_HALF     = 5;
  localparam int ITEM_TARGET  = 1700;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 40;
  // limit sized for the slowest legal run of roughly 1750 pixels, with its gaps and the hold
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  pix_valid;
  logic                  pix_ready;
  logic [7:0]            pixel;
  logic                  res_valid;
  logic                  res_ready;
  logic [VALUE_W-1:0]    res_value;
  logic [OUT_IDX_W-1:0]  res_row;
  logic [OUT_IDX_W-1:0]  res_col;
  logic                  res_last;
  int                    mismatches;
  int                    pending;
  int                    results;

  // stimulus bookkeeping: where the next pixel lands in the frame
  int unsigned tb_cols;
  int unsigned tb_rows;
  int unsigned col_pos;
  int unsigned row_pos;
  int          sent;
  int          frames_done;
  int          settings_run;
  int          hold_cycles;
  bit          send_burst;
  bit          recv_burst;
  int unsigned cycle_count = 0;

  image_correlate_3x3 u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (pix_valid),
    .in_ready_o   (pix_ready),
    .pixel_i      (pixel),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .value_o      (res_value),
    .out_row_o    (res_row),
    .out_col_o    (res_col),
    .frame_last_o (res_last)
  );

  correlation_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (pix_valid),
    .in_ready_i   (pix_ready),
    .pixel_i      (pixel),
    .out_valid_i  (res_valid),
    .out_ready_i  (res_ready),
    .value_i      (res_value),
    .out_row_i    (res_row),
    .out_col_i    (res_col),
    .frame_last_i (res_last),
    .errors_o     (mismatches),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** image_correlate_3x3: FAILED **");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] next_pixel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: return COEF_W'($urandom_range(0, 64) - 32);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_kernel_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] px);
    int gap;
    bit pause;
    gap   = pick_gap(send_burst);
    pause = !send_burst && ($urandom_range(0, 149) == 0);
    if (pause) gap = gap + 1;
    @(negedge clk);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      // now and then let the block run dry before the next beat
      while (pause && pending != 0) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pixel     <= px;
    do @(posedge clk); while (!pix_ready);
    sent++;
    if (col_pos + 1 >= tb_cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= tb_rows) ? 0 : row_pos + 1;
      if (row_pos == 0) frames_done++;
    end else begin
      col_pos++;
    end
  endtask

  // stop offering, wait for every expected beat, then let the last pixel finish
  task automatic settle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure();
    bit          at_start;
    int          roll;
    int unsigned new_cols;
    int unsigned new_rows;
    logic [SCALE_W-1:0] scale_val;
    at_start = (col_pos == 0) && (row_pos == 0);
    if ($urandom_range(0, 1)) write_reg(REG_KERN_TOP, pick_kernel_row());
    if ($urandom_range(0, 1)) write_reg(REG_KERN_MID, pick_kernel_row());
    if ($urandom_range(0, 1)) write_reg(REG_KERN_BOT, pick_kernel_row());
    if ($urandom_range(0, 1)) begin
      roll = $urandom_range(0, 9);
      case (roll)
        0: scale_val = SCALE_ONE;
        1: scale_val = 32'h8000_0000;
        2: scale_val = 32'h7FFF_FFFF;
        3: scale_val = '0;
        4: scale_val = -SCALE_ONE;
        5, 6: scale_val = $urandom_range(0, 1 << 18) - (1 << 17);
        default: scale_val = $urandom();
      endcase
      write_reg(REG_SCALE, CFG_W'(scale_val));
    end
    if ($urandom_range(0, 19) == 0) write_reg(REG_SPARE, CFG_W'({$urandom(), $urandom()}));
    if (tb_rows > 8 || $urandom_range(0, 2) == 0) begin
      // line stores only hold what earlier rows of this frame wrote: widen at frame start only
      if (at_start) begin
        roll = $urandom_range(0, 19);
        if (roll < 16) new_cols = $urandom_range(3, 10);
        else if (roll < 19) new_cols = $urandom_range(11, 40);
        else new_cols = $urandom_range(60, 160);
      end else begin
        new_cols = $urandom_range(3, tb_cols);
      end
      new_rows = (new_cols > 40) ? $urandom_range(3, 4) : $urandom_range(3, 8);
      write_reg(REG_COLS, CFG_W'(new_cols));
      write_reg(REG_ROWS, CFG_W'(new_rows));
      tb_cols = new_cols;
      tb_rows = new_rows;
    end
    send_burst = ($urandom_range(0, 4) == 0);
  endtask

  // result side: random stalls, one long hold-off once beats are flowing
  initial begin
    bit hold_done;
    int gap;
    hold_done = 1'b0;
    res_ready = 1'b0;
    recv_burst = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
      if (!hold_done && results >= HOLD_AFTER) begin
        res_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_done = 1'b1;
      end else begin
        gap = pick_gap(recv_burst);
        if (gap == 0) begin
          res_ready <= 1'b1;
        end else begin
          res_ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    logic [7:0] burst_b [12];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_KERN_TOP;
    cfg_data     = '0;
    pix_valid    = 1'b0;
    pixel        = '0;
    tb_cols      = SIZE_RST;
    tb_rows      = SIZE_RST;
    col_pos      = 0;
    row_pos      = 0;
    sent         = 0;
    frames_done  = 0;
    settings_run = 0;
    send_burst   = 1'b0;
    burst_b = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h00, 8'hAA, 8'h55, 8'hFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // smallest frame with kernel and scale at their reset values
    write_reg(REG_COLS, CFG_W'(3));
    write_reg(REG_ROWS, CFG_W'(3));
    tb_cols = 3;
    tb_rows = 3;
    for (int i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
    settle();

    // extreme coefficients, max scale, sizes given with junk high bits and below the minimum
    write_reg(REG_KERN_TOP, 48'h8000_7FFF_0001);
    write_reg(REG_KERN_MID, 48'hFFFF_0000_7FFF);
    write_reg(REG_KERN_BOT, 48'h7FFF_8000_FFFF);
    write_reg(REG_SCALE, CFG_W'(32'h7FFF_FFFF));
    write_reg(REG_COLS, 48'hFFFF_FFFF_F804);
    write_reg(REG_ROWS, '0);
    tb_cols = 4;
    tb_rows = 3;
    foreach (burst_b[i]) send_pixel(burst_b[i]);
    settle();

    // oversize frame clamps to the maximum, then the width shrinks in the middle of row 0
    write_reg(REG_COLS, CFG_W'(1500));
    write_reg(REG_ROWS, CFG_W'(11'h7FF));
    tb_cols = SIZE_RST;
    tb_rows = SIZE_RST;
    repeat (4) send_pixel(next_pixel());
    settle();
    write_reg(REG_COLS, CFG_W'(3));
    tb_cols = 3;
    repeat (7) send_pixel(next_pixel());

    while (sent < ITEM_TARGET) begin
      settle();
      reconfigure();
      settings_run++;
      if ($urandom_range(0, 1)) begin
        do send_pixel(next_pixel()); while (!(col_pos == 0 && row_pos == 0));
      end else begin
        repeat ($urandom_range(1, tb_cols * tb_rows)) send_pixel(next_pixel());
      end
    end

    settle();
    $display("run: %0d pixels over %0d register settings, %0d frames completed",
             sent, settings_run + 3, frames_done);
    $display("run: %0d result beats compared in %0d cycles", results, cycle_count);
    if (mismatches == 0 && pending == 0) begin
      $display("** image_correlate_3x3: PASSED **");
    end else begin
      $display("** image_correlate_3x3: FAILED **");
    end
    $finish;
  end

endmodule
